/* hdl/mt_pkg.sv */
package mt_pkg;

  localparam int STATE_WORDS  = 624;
  localparam int SHIFT_OFFSET = 397;
  localparam int IDX_W        = 10;
  localparam int WORD_W       = 32;

  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(STATE_WORDS - 1);
  localparam logic [IDX_W-1:0] FAR_WRAP  = IDX_W'(STATE_WORDS - SHIFT_OFFSET);
  localparam logic [IDX_W-1:0] FAR_STEP  = IDX_W'(SHIFT_OFFSET);

  localparam logic [WORD_W-1:0] INIT_MULT    = 32'd1812433253;
  localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd5489;
  localparam logic [WORD_W-1:0] TWIST_XOR    = 32'h9908b0df;
  localparam logic [WORD_W-1:0] HIGH_BIT     = 32'h80000000;
  localparam logic [WORD_W-1:0] LOW_BITS     = 32'h7fffffff;
  localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c5680;
  localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc60000;

  localparam logic ACT_GEN  = 1'b0;
  localparam logic ACT_SEED = 1'b1;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [IDX_W-1:0]  idx_t;

  typedef struct packed {
    logic seed_start;
    logic seed_default;
    logic seed_step;
    logic rd_near;
    logic rd_far;
    logic commit;
  } mt_cmd_t;

  typedef struct packed {
    logic seed_last;
    logic out_full;
  } mt_sts_t;

  function automatic word_t mt_twist(word_t a, word_t b, word_t c);
    word_t y;
    word_t v;
    y = (a & HIGH_BIT) | (b & LOW_BITS);
    v = c ^ (y >> 1);
    if (y[0]) begin
      v = v ^ TWIST_XOR;
    end
    return v;
  endfunction

  function automatic word_t mt_temper(word_t x);
    word_t y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

/* hdl/mt_if.sv */
interface mt_in_if import mt_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  action;
  word_t seed;

  modport source (output valid, output action, output seed, input ready);
  modport sink (input valid, input action, input seed, output ready);
endinterface

interface mt_out_if import mt_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t word;

  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

/* hdl/mt_ctrl.sv */
module mt_ctrl import mt_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_action,
  output logic    in_ready,
  input  mt_sts_t sts,
  output mt_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SEED = 3'd1;
  localparam logic [2:0] S_NEAR = 3'd2;
  localparam logic [2:0] S_FAR  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       seeded_r, seeded_nxt;
  logic       gen_pend_r, gen_pend_nxt;
  logic       accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt    = state_r;
    seeded_nxt   = seeded_r;
    gen_pend_nxt = gen_pend_r;
    cmd          = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_action == ACT_SEED) begin
            cmd.seed_start = 1'b1;
            gen_pend_nxt   = 1'b0;
            state_nxt      = S_SEED;
          end else if (!seeded_r) begin
            cmd.seed_start   = 1'b1;
            cmd.seed_default = 1'b1;
            gen_pend_nxt     = 1'b1;
            state_nxt        = S_SEED;
          end else begin
            state_nxt = S_NEAR;
          end
        end
      end
      S_SEED: begin
        cmd.seed_step = 1'b1;
        if (sts.seed_last) begin
          seeded_nxt = 1'b1;
          state_nxt  = gen_pend_r ? S_NEAR : S_IDLE;
        end
      end
      S_NEAR: begin
        cmd.rd_near = 1'b1;
        state_nxt   = S_FAR;
      end
      S_FAR: begin
        cmd.rd_far = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_full) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      seeded_r   <= 1'b0;
      gen_pend_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      seeded_r   <= seeded_nxt;
      gen_pend_r <= gen_pend_nxt;
    end
  end

`ifndef SYNTHESIS
  a_seed_before_read: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd_near || cmd.rd_far || cmd.commit) |-> seeded_r)
    else $error("table read before seeding");

  a_seed_ends_flagged: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.seed_step && sts.seed_last) |=> seeded_r)
    else $error("seeded flag not set after fill");

  a_near_then_far: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_near |=> cmd.rd_far)
    else $error("far read did not follow near read");
`endif

endmodule

/* hdl/mt_dp.sv */
module mt_dp import mt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  word_t    seed_in,
  input  mt_cmd_t  cmd,
  output mt_sts_t  sts,
  mt_out_if.source out_ch
);

  word_t mem [STATE_WORDS];

  idx_t  pos_r, pos_nxt;
  idx_t  seed_idx_r, seed_idx_nxt;
  word_t prev_r, prev_nxt;
  word_t rda_r;
  word_t rdb_r;
  word_t a_r;
  word_t out_word_r;
  logic  out_valid_r, out_valid_nxt;

  idx_t  nxt_idx;
  idx_t  far_idx;
  idx_t  rda_addr;
  word_t seed_val;
  word_t mix;
  word_t prod;
  word_t fill_val;
  word_t twisted;
  logic  wr_en;
  idx_t  wr_addr;
  word_t wr_data;

  assign nxt_idx  = (pos_r == LAST_IDX) ? '0 : pos_r + 1'b1;
  assign far_idx  = (pos_r >= FAR_WRAP) ? pos_r - FAR_WRAP : pos_r + FAR_STEP;
  assign rda_addr = cmd.rd_far ? far_idx : pos_r;
  assign seed_val = cmd.seed_default ? DEFAULT_SEED : seed_in;

  assign mix      = prev_r ^ (prev_r >> 30);
  assign prod     = INIT_MULT * mix;
  assign fill_val = prod + word_t'(seed_idx_r);
  assign twisted  = mt_twist(a_r, rdb_r, rda_r);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos_r;
    wr_data = twisted;
    if (cmd.seed_start) begin
      wr_en   = 1'b1;
      wr_addr = '0;
      wr_data = seed_val;
    end else if (cmd.seed_step) begin
      wr_en   = 1'b1;
      wr_addr = seed_idx_r;
      wr_data = fill_val;
    end else if (cmd.commit) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_near || cmd.rd_far) begin
      rda_r <= mem[rda_addr];
    end
    if (cmd.rd_near) begin
      rdb_r <= mem[nxt_idx];
    end
  end

  always_comb begin
    pos_nxt       = pos_r;
    seed_idx_nxt  = seed_idx_r;
    prev_nxt      = prev_r;
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.seed_start) begin
      pos_nxt      = '0;
      seed_idx_nxt = idx_t'(1);
      prev_nxt     = seed_val;
    end else if (cmd.seed_step) begin
      seed_idx_nxt = seed_idx_r + 1'b1;
      prev_nxt     = fill_val;
    end
    if (cmd.commit) begin
      pos_nxt       = nxt_idx;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      seed_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      seed_idx_r  <= seed_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_r <= prev_nxt;
    if (cmd.rd_far) begin
      a_r <= rda_r;
    end
    if (cmd.commit) begin
      out_word_r <= mt_temper(twisted);
    end
  end

  assign sts.seed_last = (seed_idx_r == LAST_IDX);
  assign sts.out_full  = out_valid_r && !out_ch.ready;

  assign out_ch.valid = out_valid_r;
  assign out_ch.word  = out_word_r;

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= LAST_IDX)
    else $error("position out of table");

  a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !(out_valid_r && !out_ch.ready))
    else $error("beat overwritten before taken");

  a_seed_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.seed_step |-> (seed_idx_r != '0) && (seed_idx_r <= LAST_IDX))
    else $error("fill index out of range");

  a_beat_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.commit))
    else $error("beat without commit");
`endif

endmodule

/* hdl/mersenne_twister_generator_top.sv */
// 32-bit mt19937 word generator
// input channel in_ch: one beat carries action and seed. action 1 reseeds the
// 624-word table from seed and gives no output beat; action 0 asks for one word.
// output channel out_ch: one beat per word request, the tempered 32-bit word.
// a word request goes from accept to out_ch.valid through a read of the word and
// its neighbor, a read of the far word, then twist, write-back and temper. the
// twist is done per word, so there is no whole-table pause between blocks.
// a new request is accepted only in idle, after the previous one has committed;
// its steps run in turn through the table memory's read ports and registered data.
// a reseed fills the table one word per cycle through the seed multiplier;
// in_ch.ready is low meanwhile.
// a word request before any seed first fills the table from seed 5489 and then
// produces its word from that table.
// reset (rst_n low, synchronous) clears the seeded flag, the read position and
// the output beat; table contents are left as they are.
// a stalled out_ch holds its beat; the next request may be accepted and is held
// in its last step until the output slot frees.
module mersenne_twister_generator_top import mt_pkg::*; (
  input logic    clk,
  input logic    rst_n,
  mt_in_if.sink  in_ch,
  mt_out_if.source out_ch
);

  mt_cmd_t cmd;
  mt_sts_t sts;

  mt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mt_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .seed_in (in_ch.seed),
    .cmd     (cmd),
    .sts     (sts),
    .out_ch  (out_ch)
  );

endmodule
